// ===== rtl/sarg_pkg.sv =====
// ----------------------------------------------------------------------------
// sarg_pkg
// Shared types and constants of the sound activated recording gate.
// ----------------------------------------------------------------------------
`default_nettype none

package sarg_pkg;

    localparam int SampleW = 16;
    localparam int SquareW = 31;   // largest square is 2^30
    localparam int EnergyW = 46;
    localparam int TimeW   = 32;
    localparam int CountW  = 16;
    localparam int OpW     = 3;
    localparam int RegIdxW = 2;

    localparam logic [CountW-1:0] BlockLenReset = 16'd1600;

    typedef enum logic [OpW-1:0] {
        OP_SAMPLE = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_PAUSE  = 3'd3,
        OP_RESUME = 3'd4
    } op_t;

    typedef enum logic [RegIdxW-1:0] {
        REG_BLOCK_LEN       = 2'd0,
        REG_ENERGY_THRESH   = 2'd1,
        REG_SILENCE_TIMEOUT = 2'd2,
        REG_MIN_DURATION    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CountW-1:0]  block_len;
        logic [EnergyW-1:0] energy_threshold;
        logic [TimeW-1:0]   silence_timeout;
        logic [TimeW-1:0]   min_duration;
    } cfg_t;

    typedef struct packed {
        logic [TimeW-1:0] duration;
        logic             active;
        logic             chunk_ready;
        logic             stopped;
        logic             started;
        logic             loud;
        logic             block_done;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sound_activated_recording_gate_core.sv =====
// ----------------------------------------------------------------------------
// sound_activated_recording_gate_core
// Energy voice activity detector with hangover, stream in, stream out.
// ----------------------------------------------------------------------------
// Accepts one beat per clock cycle and returns exactly one result beat for
// each input beat, in order. The input register holds the op code and the
// registered square of the sample, the result register holds the outcome of
// the single state update of the block accumulator and recording state; a
// new beat can enter every cycle as long as the result side keeps taking
// beats. Registers sit on the APB port at byte addresses 0, 8, 16 and 24
// (block_len, energy_threshold, silence_timeout, min_duration); write them
// only while no beat is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_activated_recording_gate_core
    import sarg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample (signed)
    input  logic [2:0]  s_tuser,   // [2:0] op

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [0] block_done, [1] loud, [2] started,
                                   // [3] stopped, [4] chunk_ready, [5] active,
                                   // [37:6] duration, [39:38] zero

    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_len        <= BlockLenReset;
            cfg_reg.energy_threshold <= '0;
            cfg_reg.silence_timeout  <= '0;
            cfg_reg.min_duration     <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_BLOCK_LEN:       cfg_reg.block_len        <= pwdata[CountW-1:0];
                REG_ENERGY_THRESH:   cfg_reg.energy_threshold <= pwdata[EnergyW-1:0];
                REG_SILENCE_TIMEOUT: cfg_reg.silence_timeout  <= pwdata[TimeW-1:0];
                REG_MIN_DURATION:    cfg_reg.min_duration     <= pwdata[TimeW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb
    begin
        case (reg_idx)
            REG_BLOCK_LEN:       prdata = 64'(cfg_reg.block_len);
            REG_ENERGY_THRESH:   prdata = 64'(cfg_reg.energy_threshold);
            REG_SILENCE_TIMEOUT: prdata = 64'(cfg_reg.silence_timeout);
            REG_MIN_DURATION:    prdata = 64'(cfg_reg.min_duration);
            default:             prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: hold op and the squared sample
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    op_t                   in_op_reg;
    logic [SquareW-1:0]    in_sq_reg;
    logic signed [SampleW-1:0] sample_s;
    logic signed [31:0]    product;
    logic                  in_beat;
    logic                  advance;

    assign sample_s = $signed(s_tdata);
    assign product  = sample_s * sample_s;

    // Advance the held beat whenever the result register is empty or drains.
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_beat  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset; capture only on an accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            in_op_reg <= op_t'(s_tuser);
            in_sq_reg <= product[SquareW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Detector state update
    // ------------------------------------------------------------------
    result_t result;

    sarg_gate u_gate (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .op     (in_op_reg),
        .square (in_sq_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic    out_valid_reg;
    result_t out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Block flags only appear on a completed block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_res_reg.loud || out_res_reg.chunk_ready
                     || out_res_reg.started)
        |-> out_res_reg.block_done)
        else $error("block flag without a completed block");

    // A stopped recording is never reported active.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_res_reg.stopped |-> !out_res_reg.active)
        else $error("stopped beat reports active recording");

    // A beat that advances always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat lost before the result register");

    // Start and stop never share one block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_res_reg.started && out_res_reg.stopped))
        else $error("start and stop on the same block");

endmodule

`default_nettype wire

// ===== rtl/sarg_gate.sv =====
// ----------------------------------------------------------------------------
// sarg_gate
// Detector state: block energy, sample clock, recording control, result.
// ----------------------------------------------------------------------------
`default_nettype none

module sarg_gate
    import sarg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  op_t                op,
    input  logic [SquareW-1:0] square,
    input  cfg_t               cfg,
    output result_t            result
);

    logic [EnergyW-1:0] acc_reg, acc_next;
    logic [CountW-1:0]  cnt_reg, cnt_next;
    logic [TimeW-1:0]   clock_reg, clock_next;
    logic [TimeW-1:0]   last_loud_reg, last_loud_next;
    logic [TimeW-1:0]   start_reg, start_next;
    logic               rec_reg, rec_next;
    logic               paused_reg, paused_next;
    logic               running_reg, running_next;

    logic [EnergyW-1:0] acc_sum;
    logic [CountW:0]    cnt_inc;
    logic [CountW:0]    target;
    logic [TimeW-1:0]   now;
    logic [TimeW-1:0]   quiet_time;
    logic [TimeW-1:0]   rec_len;
    logic               blk_end;
    logic               blk_loud;
    logic               silence_stop;
    result_t            res;

    assign acc_sum    = acc_reg + EnergyW'(square);
    assign cnt_inc    = {1'b0, cnt_reg} + 1'b1;
    assign target     = {(cfg.block_len == '0), cfg.block_len};
    assign now        = clock_reg + 1'b1;
    assign quiet_time = now - last_loud_reg;
    assign rec_len    = now - start_reg;
    assign blk_end    = running_reg && (cnt_inc >= target);
    assign blk_loud   = acc_sum > cfg.energy_threshold;
    // A loud block resets the quiet time to zero, so only a quiet block stops.
    assign silence_stop = rec_reg && !paused_reg && !blk_loud
                          && (cfg.silence_timeout != '0)
                          && (quiet_time > cfg.silence_timeout)
                          && (rec_len >= cfg.min_duration);

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        clock_next     = clock_reg;
        last_loud_next = last_loud_reg;
        start_next     = start_reg;
        rec_next       = rec_reg;
        paused_next    = paused_reg;
        running_next   = running_reg;
        res            = '0;

        case (op)
            OP_SAMPLE:
            begin
                clock_next = now;
                if (running_reg)
                begin
                    if (blk_end)
                    begin
                        res.block_done = 1'b1;
                        acc_next       = '0;
                        cnt_next       = '0;
                        if (blk_loud)
                        begin
                            res.loud       = 1'b1;
                            last_loud_next = now;
                            if (!rec_reg)
                            begin
                                rec_next    = 1'b1;
                                start_next  = now;
                                res.started = 1'b1;
                            end
                        end
                        if ((rec_reg || blk_loud) && !paused_reg)
                        begin
                            res.chunk_ready = 1'b1;
                        end
                        if (silence_stop)
                        begin
                            rec_next    = 1'b0;
                            res.stopped = 1'b1;
                        end
                    end
                    else
                    begin
                        acc_next = acc_sum;
                        cnt_next = cnt_inc[CountW-1:0];
                    end
                end
            end
            OP_START:
            begin
                running_next = 1'b1;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                rec_next     = 1'b0;
                paused_next  = 1'b0;
                acc_next     = '0;
                cnt_next     = '0;
            end
            OP_PAUSE:
            begin
                paused_next = 1'b1;
            end
            OP_RESUME:
            begin
                paused_next    = 1'b0;
                last_loud_next = clock_reg;
            end
            default:
            begin
            end
        endcase

        res.active = rec_next && !paused_next;
        // On a stop the start time still holds, so this is the final length.
        res.duration = (rec_next || res.stopped) ? (clock_next - start_next) : '0;
    end

    assign result = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            clock_reg     <= '0;
            last_loud_reg <= '0;
            start_reg     <= '0;
            rec_reg       <= 1'b0;
            paused_reg    <= 1'b0;
            running_reg   <= 1'b0;
        end
        else if (step)
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            clock_reg     <= clock_next;
            last_loud_reg <= last_loud_next;
            start_reg     <= start_next;
            rec_reg       <= rec_next;
            paused_reg    <= paused_next;
            running_reg   <= running_next;
        end
    end

    // Counter never reaches the block target outside a block end.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !blk_end && running_reg && op == OP_SAMPLE
        |=> ({1'b0, cnt_reg} < target || $past(cfg.block_len) != cfg.block_len))
        else $error("block counter passed its target");

    // Recording cannot be held while the gate is stopped by an explicit stop.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && op == OP_STOP |=> !rec_reg && !running_reg && acc_reg == '0)
        else $error("stop did not clear recording state");

    // A stop by silence always reports a completed, non-loud block.
    assert property (@(posedge clk) disable iff (!rst_n)
        res.stopped |-> res.block_done && !res.loud && !res.started)
        else $error("silence stop on a loud or unfinished block");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sound activated recording gate core.
// ----------------------------------------------------------------------------
// A queue of input beats feeds a clocked stream driver. Each accepted beat runs
// through a local model of the energy detector and recording state. The model
// result is queued, and a clocked monitor checks every result beat against the
// oldest queued result, field by field. Registers go through the APB port
// between phases, only once the gate has drained. Phases cover beats under the
// reset register values, a short directed run, random traffic under several
// register settings and idle patterns, and the two longest block lengths.
// ----------------------------------------------------------------------------

module tb;
    import sarg_pkg::*;

    localparam int CycleLimit = 20000;
    localparam int DrainCycles = 4;
    // op codes the gate must treat as no operation
    localparam logic [OpW-1:0] OpUndefLo = 3'd5;
    localparam logic [OpW-1:0] OpUndefHi = 3'd7;
    localparam logic [EnergyW-1:0] EnergyMax = '1;
    localparam logic [TimeW-1:0] TimeMax = '1;

    typedef struct {
        logic [OpW-1:0]     op;
        logic [SampleW-1:0] sample;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Input beats not yet offered, and results owed by the gate, oldest first
    beat_t   in_beats[$];
    result_t due_results[$];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int cycles;

    // Local copy of the registers and of the detector state
    cfg_t               gate_cfg;
    logic [EnergyW-1:0] energy_sum;
    logic [CountW:0]    blk_fill;
    logic [TimeW-1:0]   now_clk;
    logic [TimeW-1:0]   loud_at;
    logic [TimeW-1:0]   rec_start;
    bit                 rec_on;
    bit                 rec_paused;
    bit                 det_running;

    beat_t   drv_beat;
    result_t mon_got;
    result_t mon_want;

    sound_activated_recording_gate_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] sample (signed)
        .s_tuser  (s_tuser),   // [2:0] op
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [0] block_done, [1] loud, [2] started, [3] stopped,
                               // [4] chunk_ready, [5] active, [37:6] duration
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Compute the result of one accepted beat and advance the detector state
    function automatic result_t gate_update(logic [OpW-1:0] op, logic [SampleW-1:0] raw);
        result_t          r;
        longint           sx;
        logic [EnergyW-1:0] sq;
        logic [CountW:0]  target;
        logic [TimeW-1:0] len;
        r = '0;
        len = '0;
        case (op)
            OP_SAMPLE:
            begin
                now_clk = now_clk + 1;
                if (det_running)
                begin
                    sx = $signed(raw);
                    sq = EnergyW'(sx * sx);
                    // a zero block length stands for the full 16-bit count
                    target = (gate_cfg.block_len == 0) ? 17'h10000 : {1'b0, gate_cfg.block_len};
                    energy_sum = energy_sum + sq;
                    blk_fill = blk_fill + 1'b1;
                    if (blk_fill >= target)
                    begin
                        r.block_done = 1'b1;
                        if (energy_sum > gate_cfg.energy_threshold)
                        begin
                            r.loud = 1'b1;
                            loud_at = now_clk;
                            if (!rec_on)
                            begin
                                rec_on = 1'b1;
                                rec_start = now_clk;
                                r.started = 1'b1;
                            end
                        end
                        if (rec_on && !rec_paused)
                        begin
                            r.chunk_ready = 1'b1;
                            if (gate_cfg.silence_timeout != 0 &&
                                (now_clk - loud_at) > gate_cfg.silence_timeout)
                            begin
                                len = now_clk - rec_start;
                                if (len >= gate_cfg.min_duration)
                                begin
                                    rec_on = 1'b0;
                                    r.stopped = 1'b1;
                                end
                            end
                        end
                        energy_sum = '0;
                        blk_fill = '0;
                    end
                    blk_fill[CountW] = 1'b0;
                end
            end
            OP_START:
                det_running = 1'b1;
            OP_STOP:
            begin
                det_running = 1'b0;
                rec_on = 1'b0;
                rec_paused = 1'b0;
                energy_sum = '0;
                blk_fill = '0;
            end
            OP_PAUSE:
                rec_paused = 1'b1;
            OP_RESUME:
            begin
                rec_paused = 1'b0;
                loud_at = now_clk;
            end
            default:
                ;
        endcase
        r.active = rec_on && !rec_paused;
        if (r.stopped)
            r.duration = len;
        else if (rec_on)
            r.duration = now_clk - rec_start;
        else
            r.duration = '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycles, what, got, want);
        errors++;
    endtask

    // Stream driver: predict on acceptance, then offer the next beat or idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                due_results.push_back(gate_update(s_tuser, s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (in_beats.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_beat = in_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= drv_beat.op;
                    s_tdata <= drv_beat.sample;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted result beat, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                mon_got = m_tdata[37:0];
                if (due_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing owed", m_tdata[31:0], '0);
                end
                else
                begin
                    mon_want = due_results.pop_front();
                    if (mon_got.block_done !== mon_want.block_done)
                        report_mismatch("block_done", 32'(mon_got.block_done),
                                        32'(mon_want.block_done));
                    if (mon_got.loud !== mon_want.loud)
                        report_mismatch("loud", 32'(mon_got.loud), 32'(mon_want.loud));
                    if (mon_got.started !== mon_want.started)
                        report_mismatch("started", 32'(mon_got.started),
                                        32'(mon_want.started));
                    if (mon_got.stopped !== mon_want.stopped)
                        report_mismatch("stopped", 32'(mon_got.stopped),
                                        32'(mon_want.stopped));
                    if (mon_got.chunk_ready !== mon_want.chunk_ready)
                        report_mismatch("chunk_ready", 32'(mon_got.chunk_ready),
                                        32'(mon_want.chunk_ready));
                    if (mon_got.active !== mon_want.active)
                        report_mismatch("active", 32'(mon_got.active),
                                        32'(mon_want.active));
                    if (mon_got.duration !== mon_want.duration)
                        report_mismatch("duration", mon_got.duration, mon_want.duration);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if the gate stops making progress
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_beat(logic [OpW-1:0] op, logic [SampleW-1:0] sample);
        beat_t b;
        b.op = op;
        b.sample = sample;
        in_beats.push_back(b);
    endtask

    // Hold until every beat went in and every owed result came back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (in_beats.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Setup and access cycle; the register takes the value at the access edge
    task automatic apb_write(reg_idx_t idx, logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BLOCK_LEN:       gate_cfg.block_len = val[CountW-1:0];
            REG_ENERGY_THRESH:   gate_cfg.energy_threshold = val[EnergyW-1:0];
            REG_SILENCE_TIMEOUT: gate_cfg.silence_timeout = val[TimeW-1:0];
            REG_MIN_DURATION:    gate_cfg.min_duration = val[TimeW-1:0];
            default:             ;
        endcase
    endtask

    task automatic configure(logic [CountW-1:0] blk, logic [EnergyW-1:0] thr,
                             logic [TimeW-1:0] sil, logic [TimeW-1:0] mind);
        apb_write(REG_BLOCK_LEN, 64'(blk));
        apb_write(REG_ENERGY_THRESH, 64'(thr));
        apb_write(REG_SILENCE_TIMEOUT, 64'(sil));
        apb_write(REG_MIN_DURATION, 64'(mind));
    endtask

    // Random traffic: mostly loud and quiet stretches of whole blocks, so that
    // recordings start, forward chunks and time out; control ops sprinkled in
    task automatic queue_random(int count, int blk);
        int  seg_left;
        bit  seg_loud;
        int  r;
        int  q;
        seg_left = 0;
        seg_loud = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (seg_left == 0)
            begin
                seg_loud = 1'($urandom_range(1));
                seg_left = blk * $urandom_range(6, 1);
            end
            r = $urandom_range(99);
            if (r < 88)
            begin
                if (seg_loud)
                begin
                    push_beat(OP_SAMPLE, SampleW'($urandom));
                end
                else
                begin
                    q = $urandom_range(6);
                    q = q - 3;
                    if ($urandom_range(1))
                        q = 0;
                    push_beat(OP_SAMPLE, q[SampleW-1:0]);
                end
                seg_left--;
            end
            else if (r < 91)
            begin
                push_beat(OP_START, SampleW'($urandom));
            end
            else if (r < 93)
            begin
                // mostly restart right away so traffic keeps reaching the blocks
                push_beat(OP_STOP, SampleW'($urandom));
                if ($urandom_range(3) != 0)
                    push_beat(OP_START, SampleW'($urandom));
            end
            else if (r < 95)
            begin
                push_beat(OP_PAUSE, SampleW'($urandom));
            end
            else if (r < 98)
            begin
                push_beat(OP_RESUME, SampleW'($urandom));
            end
            else
            begin
                push_beat(OpW'($urandom_range(OpUndefHi, OpUndefLo)), SampleW'($urandom));
            end
        end
    endtask

    task automatic queue_noise(int count);
        for (int i = 0; i < count; i++)
            push_beat(OP_SAMPLE, SampleW'($urandom));
    endtask

    function automatic logic [EnergyW-1:0] pick_threshold(int blk);
        longint t;
        t = longint'(blk) * longint'($urandom_range(100000, 40));
        return t[EnergyW-1:0];
    endfunction

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 13;
        recv_idle_pct = 71;
        gate_cfg = '0;
        gate_cfg.block_len = BlockLenReset;
        energy_sum = '0;
        blk_fill = '0;
        now_clk = '0;
        loud_at = '0;
        rec_start = '0;
        rec_on = 1'b0;
        rec_paused = 1'b0;
        det_running = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // A few beats under the reset register values
        push_beat(OP_SAMPLE, 16'h7FFF);
        push_beat(OP_START, 16'h0000);
        push_beat(OP_SAMPLE, 16'hFFFF);
        push_beat(OP_STOP, 16'hFFFF);
        wait_drained();

        // Directed walk through start, loud block, timeout stop, pause, resume
        configure(16'd2, 46'd100, 32'd4, 32'd0);
        push_beat(OP_SAMPLE, 16'h8000);          // not running: clock only
        push_beat(OP_START, 16'h0000);
        push_beat(OP_START, 16'h0000);           // already running: no effect
        push_beat(OP_SAMPLE, 16'h7FFF);
        push_beat(OP_SAMPLE, 16'h8000);          // loud block starts recording
        push_beat(OP_SAMPLE, 16'h0000);
        push_beat(OP_SAMPLE, 16'h0000);
        push_beat(OP_SAMPLE, 16'h0000);
        push_beat(OP_SAMPLE, 16'h0000);
        push_beat(OP_SAMPLE, 16'h0000);
        push_beat(OP_SAMPLE, 16'h0000);          // quiet past the timeout: stop
        push_beat(OP_SAMPLE, 16'h0000);
        push_beat(OP_SAMPLE, 16'h0000);          // silent block, never loud
        push_beat(OP_PAUSE, 16'h0000);
        push_beat(OP_SAMPLE, 16'h8000);
        push_beat(OP_SAMPLE, 16'h8000);          // starts while paused: no chunk
        push_beat(OP_RESUME, 16'h0000);
        push_beat(OP_SAMPLE, 16'h0001);
        push_beat(OP_SAMPLE, 16'h0001);
        push_beat(OpUndefLo, 16'hFFFF);
        push_beat(OpUndefHi, 16'h5555);
        push_beat(OP_STOP, 16'h0000);
        push_beat(OP_SAMPLE, 16'h0005);
        wait_drained();

        // Sender idles rarely, receiver stalls most of the time
        send_idle_pct = 13;
        recv_idle_pct = 71;
        configure(16'd4, pick_threshold(4), 32'd12, 32'd0);
        push_beat(OP_START, 16'h0000);
        queue_random(150, 4);
        wait_drained();
        configure(16'd1, 46'd0, 32'd0, 32'd0);
        queue_random(150, 1);
        wait_drained();

        // Swap the idle pattern
        send_idle_pct = 71;
        recv_idle_pct = 13;
        configure(16'd3, EnergyMax, TimeMax, TimeMax);
        queue_random(150, 3);
        wait_drained();
        configure(16'd8, pick_threshold(8), 32'd20, 32'd40);
        queue_random(150, 8);
        wait_drained();

        // No idling; drain once mid-stream with the registers left alone
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(16'd5, pick_threshold(5), $urandom_range(30, 5), $urandom_range(50));
        queue_random(100, 5);
        wait_drained();
        queue_random(100, 5);
        wait_drained();

        // Longest blocks: the full register value, then zero for 65536 samples;
        // keep the runs short, so no block completes here
        configure(16'hFFFF, 46'd0, 32'd100000, 32'd0);
        push_beat(OP_START, 16'h0000);
        queue_noise(20);
        wait_drained();
        apb_write(REG_BLOCK_LEN, 64'd0);
        queue_noise(20);
        wait_drained();

        repeat (DrainCycles * 4) @(posedge clk);
        if (errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
